// ----- hdl/smt_pkg.sv -----
// Shared constants and types for the sorted multiset table.
`timescale 1ns / 1ps
`default_nettype none

package smt_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int KEY_BITS_DEF   = 32;
	localparam int COUNT_BITS_DEF = 32;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_AMOUNT = 3'd1;
	localparam logic [2:0] ST_EMPTY      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
	localparam logic [2:0] ST_FULL       = 3'd4;

	// control broadcast to every cell
	typedef struct packed {
		logic cmp;     // compare stored key against the incoming key
		logic set_cnt; // matching cell loads new count
		logic ins;     // open a slot at the insert point, later cells move up
		logic del;     // drop the matching cell, later cells move down
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/smt_cell.sv -----
// One table cell: a key, its count and a valid bit, with neighbour shifting.
`timescale 1ns / 1ps
`default_nettype none

module smt_cell #(
	parameter int KEY_BITS   = smt_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS = smt_pkg::COUNT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire smt_pkg::cell_ctl_t           ctl,
	input  wire logic signed [KEY_BITS-1:0]   bcast_key,
	input  wire logic [COUNT_BITS-1:0]        new_count,
	input  wire logic                         left_lt,
	input  wire logic                         left_valid,
	input  wire logic signed [KEY_BITS-1:0]   left_key,
	input  wire logic [COUNT_BITS-1:0]        left_count,
	input  wire logic                         right_valid,
	input  wire logic signed [KEY_BITS-1:0]   right_key,
	input  wire logic [COUNT_BITS-1:0]        right_count,
	output logic                              valid,
	output logic                              lt,
	output logic                              eq,
	output logic signed [KEY_BITS-1:0]        key_out,
	output logic [COUNT_BITS-1:0]             count_out
);
	import smt_pkg::*;

	logic                       valid_q;
	logic                       lt_q;
	logic                       eq_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [COUNT_BITS-1:0]      count_q;
	logic                       moves;

	// cells at or beyond the insert/match point take part in a shift
	assign moves = !lt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (ctl.cmp) begin
				lt_q <= valid_q && (key_q < bcast_key);
				eq_q <= valid_q && (key_q == bcast_key);
			end
			if (ctl.ins && moves) begin
				valid_q <= left_lt ? 1'b1 : left_valid;
			end else if (ctl.del && moves) begin
				valid_q <= right_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.set_cnt && eq_q) begin
			count_q <= new_count;
		end else if (ctl.ins && moves) begin
			if (left_lt) begin
				key_q   <= bcast_key;
				count_q <= new_count;
			end else begin
				key_q   <= left_key;
				count_q <= left_count;
			end
		end else if (ctl.del && moves) begin
			key_q   <= right_key;
			count_q <= right_count;
		end
	end

	assign valid     = valid_q;
	assign lt        = lt_q;
	assign eq        = eq_q;
	assign key_out   = key_q;
	assign count_out = count_q;

endmodule

`default_nettype wire

// ----- hdl/sorted_multiset_table.sv -----
// Top level of the sorted multiset table: control, result register and cell row.
//
// A bag of signed keys with occurrence counts, held sorted in a row of cells.
// Input channel (in_valid/in_ready) carries one operation per beat: insert,
// remove or query of a key with an amount. Output channel (out_valid/out_ready)
// returns one beat per operation: status, resulting count and an empty flag.
// Timing: when a beat is accepted every cell compares its key at that edge; the
// update and the result register load once the result register is free, and the
// result is then visible. in_ready is low while an operation is pending, so the
// block takes a new operation only after the last one has updated the row.
// The result register parts the two sides: a new beat is taken while the last
// result waits. If the receiver stalls, the following operation holds in its
// update cycle until the result register frees, and the input stays blocked.
// Reset clears every cell's valid bit (empty bag) and drops any pending
// result; keys and counts are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_multiset_table #(
	parameter int CAPACITY   = smt_pkg::CAPACITY_DEF,
	parameter int KEY_BITS   = smt_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS = smt_pkg::COUNT_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         operation,
	input  wire logic signed [31:0] key,
	input  wire logic [31:0]        amount,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [31:0]             count,
	output logic                    is_empty
);
	import smt_pkg::*;

	localparam int WW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

	logic                       busy_q;
	logic [1:0]                 op_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [31:0]                amt_q;
	logic                       out_valid_q;
	logic [2:0]                 status_q;
	logic [31:0]                count_q;
	logic                       is_empty_q;

	logic [CAPACITY-1:0]        cell_valid;
	logic [CAPACITY-1:0]        cell_lt;
	logic [CAPACITY-1:0]        cell_eq;
	logic signed [KEY_BITS-1:0] cell_key [CAPACITY];
	logic [COUNT_BITS-1:0]      cell_count [CAPACITY];

	logic                       accept;
	logic                       fire;
	cell_ctl_t                  ctl;
	logic signed [KEY_BITS-1:0] bcast_key;
	logic [COUNT_BITS-1:0]      new_count;

	logic                       found;
	logic [COUNT_BITS-1:0]      found_cnt;
	logic [WW-1:0]              amt_w;
	logic [WW-1:0]              cmax_w;
	logic [COUNT_BITS-1:0]      amt_clip;
	logic [COUNT_BITS:0]        sum;
	logic [COUNT_BITS-1:0]      sat_sum;
	logic [COUNT_BITS-1:0]      diff;
	logic                       amt_zero;
	logic                       amt_gt;
	logic                       amt_eq;
	logic                       empty_now;
	logic                       full_now;
	logic [2:0]                 res_status;
	logic [COUNT_BITS-1:0]      res_count;
	logic                       res_empty;
	logic                       do_set;
	logic                       do_ins;
	logic                       do_del;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign fire     = busy_q && (!out_valid_q || out_ready);

	assign bcast_key = accept ? KEY_BITS'(key) : key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			key_q <= KEY_BITS'(key);
			amt_q <= amount;
		end
		if (fire) begin
			status_q   <= res_status;
			count_q    <= 32'(res_count);
			is_empty_q <= res_empty;
		end
	end

	// gather the matching cell's count; at most one cell matches
	always_comb begin
		found_cnt = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			found_cnt = found_cnt | (cell_count[i] & {COUNT_BITS{cell_eq[i]}});
		end
	end

	assign found     = |cell_eq;
	assign empty_now = !cell_valid[0];
	assign full_now  = cell_valid[CAPACITY-1];

	assign amt_w    = WW'(amt_q);
	assign cmax_w   = WW'({COUNT_BITS{1'b1}});
	assign amt_clip = (amt_w > cmax_w) ? {COUNT_BITS{1'b1}} : amt_w[COUNT_BITS-1:0];
	assign sum      = {1'b0, found_cnt} + {1'b0, amt_clip};
	assign sat_sum  = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
	assign diff     = found_cnt - amt_w[COUNT_BITS-1:0];
	assign amt_zero = (amt_q == 32'd0);
	assign amt_gt   = amt_w > WW'(found_cnt);
	assign amt_eq   = amt_w == WW'(found_cnt);

	always_comb begin
		res_status = ST_OK;
		res_count  = found ? found_cnt : '0;
		new_count  = amt_clip;
		do_set     = 1'b0;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		case (op_q)
			OP_INSERT: begin
				if (amt_zero) begin
					res_status = ST_BAD_AMOUNT;
				end else if (found) begin
					do_set    = 1'b1;
					new_count = sat_sum;
					res_count = sat_sum;
				end else if (full_now) begin
					res_status = ST_FULL;
				end else begin
					do_ins    = 1'b1;
					res_count = amt_clip;
				end
			end
			OP_REMOVE: begin
				if (amt_zero) begin
					res_status = ST_BAD_AMOUNT;
				end else if (empty_now) begin
					res_status = ST_EMPTY;
				end else if (!found) begin
					res_status = ST_NOT_FOUND;
				end else if (amt_gt) begin
					res_status = ST_BAD_AMOUNT;
				end else if (amt_eq) begin
					do_del    = 1'b1;
					res_count = '0;
				end else begin
					do_set    = 1'b1;
					new_count = diff;
					res_count = diff;
				end
			end
			default: begin
				// query, and the unused code behaves as a query
			end
		endcase
		if (do_ins) begin
			res_empty = 1'b0;
		end else if (do_del) begin
			res_empty = !cell_valid[1];
		end else begin
			res_empty = empty_now;
		end
	end

	assign ctl.cmp     = accept;
	assign ctl.set_cnt = fire && do_set;
	assign ctl.ins     = fire && do_ins;
	assign ctl.del     = fire && do_del;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                       l_lt;
		logic                       l_valid;
		logic signed [KEY_BITS-1:0] l_key;
		logic [COUNT_BITS-1:0]      l_count;
		logic                       r_valid;
		logic signed [KEY_BITS-1:0] r_key;
		logic [COUNT_BITS-1:0]      r_count;

		if (i == 0) begin : g_first
			assign l_lt    = 1'b1;
			assign l_valid = 1'b0;
			assign l_key   = '0;
			assign l_count = '0;
		end else begin : g_left
			assign l_lt    = cell_lt[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_key   = cell_key[i-1];
			assign l_count = cell_count[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_valid = 1'b0;
			assign r_key   = '0;
			assign r_count = '0;
		end else begin : g_right
			assign r_valid = cell_valid[i+1];
			assign r_key   = cell_key[i+1];
			assign r_count = cell_count[i+1];
		end

		smt_cell #(
			.KEY_BITS   (KEY_BITS),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.bcast_key   (bcast_key),
			.new_count   (new_count),
			.left_lt     (l_lt),
			.left_valid  (l_valid),
			.left_key    (l_key),
			.left_count  (l_count),
			.right_valid (r_valid),
			.right_key   (r_key),
			.right_count (r_count),
			.valid       (cell_valid[i]),
			.lt          (cell_lt[i]),
			.eq          (cell_eq[i]),
			.key_out     (cell_key[i]),
			.count_out   (cell_count[i])
		);
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign count     = count_q;
	assign is_empty  = is_empty_q;

	// occupied cells always form a prefix of the row
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, cell_valid} + {{CAPACITY{1'b0}}, 1'b1}))
		else $error("occupied cells not contiguous");

	// keys are distinct, so at most one cell matches
	a_eq_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(cell_eq))
		else $error("more than one cell matches the key");

	// smaller keys sit at the front of the row
	a_lt_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot({1'b0, cell_lt} + {{CAPACITY{1'b0}}, 1'b1}))
		else $error("less-than flags not a prefix");

	// only occupied cells may compare below or equal
	a_flags_valid: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (((cell_lt | cell_eq) & ~cell_valid) == '0))
		else $error("flag set on an empty cell");

	// a result is loaded exactly when an operation completes
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q && !busy_q)
		else $error("completed operation did not raise a result");

endmodule

`default_nettype wire
